@@ rtl/rpl_pkg.sv @@
package rpl_pkg;

   localparam int unsigned FRAC_ONE    = 4096;
   localparam int unsigned FRAC_W      = 13;   // holds 0 .. FRAC_ONE
   localparam int unsigned MAX_STEPS   = 64;
   localparam int unsigned STEP_W      = 6;    // step index 0 .. MAX_STEPS-1
   localparam int unsigned COUNT_W     = 7;    // step count 0 .. 127
   localparam int unsigned COLOR_W     = 16;
   localparam int unsigned ENTRY_W     = 4;
   localparam int unsigned CH_W        = 5;
   localparam int unsigned REQ_DATA_W  = 40;
   localparam int unsigned RSP_DATA_W  = 32;
   localparam int unsigned RST_STEPS   = 16;

   // per-step increment of the blend factor: FRAC_ONE = q*S + r
   localparam logic [FRAC_W-1:0] STEP_Q [MAX_STEPS] = '{
      13'(FRAC_ONE/1),  13'(FRAC_ONE/2),  13'(FRAC_ONE/3),  13'(FRAC_ONE/4),
      13'(FRAC_ONE/5),  13'(FRAC_ONE/6),  13'(FRAC_ONE/7),  13'(FRAC_ONE/8),
      13'(FRAC_ONE/9),  13'(FRAC_ONE/10), 13'(FRAC_ONE/11), 13'(FRAC_ONE/12),
      13'(FRAC_ONE/13), 13'(FRAC_ONE/14), 13'(FRAC_ONE/15), 13'(FRAC_ONE/16),
      13'(FRAC_ONE/17), 13'(FRAC_ONE/18), 13'(FRAC_ONE/19), 13'(FRAC_ONE/20),
      13'(FRAC_ONE/21), 13'(FRAC_ONE/22), 13'(FRAC_ONE/23), 13'(FRAC_ONE/24),
      13'(FRAC_ONE/25), 13'(FRAC_ONE/26), 13'(FRAC_ONE/27), 13'(FRAC_ONE/28),
      13'(FRAC_ONE/29), 13'(FRAC_ONE/30), 13'(FRAC_ONE/31), 13'(FRAC_ONE/32),
      13'(FRAC_ONE/33), 13'(FRAC_ONE/34), 13'(FRAC_ONE/35), 13'(FRAC_ONE/36),
      13'(FRAC_ONE/37), 13'(FRAC_ONE/38), 13'(FRAC_ONE/39), 13'(FRAC_ONE/40),
      13'(FRAC_ONE/41), 13'(FRAC_ONE/42), 13'(FRAC_ONE/43), 13'(FRAC_ONE/44),
      13'(FRAC_ONE/45), 13'(FRAC_ONE/46), 13'(FRAC_ONE/47), 13'(FRAC_ONE/48),
      13'(FRAC_ONE/49), 13'(FRAC_ONE/50), 13'(FRAC_ONE/51), 13'(FRAC_ONE/52),
      13'(FRAC_ONE/53), 13'(FRAC_ONE/54), 13'(FRAC_ONE/55), 13'(FRAC_ONE/56),
      13'(FRAC_ONE/57), 13'(FRAC_ONE/58), 13'(FRAC_ONE/59), 13'(FRAC_ONE/60),
      13'(FRAC_ONE/61), 13'(FRAC_ONE/62), 13'(FRAC_ONE/63), 13'(FRAC_ONE/64)
   };

   localparam logic [STEP_W-1:0] STEP_R [MAX_STEPS] = '{
      6'(FRAC_ONE%1),  6'(FRAC_ONE%2),  6'(FRAC_ONE%3),  6'(FRAC_ONE%4),
      6'(FRAC_ONE%5),  6'(FRAC_ONE%6),  6'(FRAC_ONE%7),  6'(FRAC_ONE%8),
      6'(FRAC_ONE%9),  6'(FRAC_ONE%10), 6'(FRAC_ONE%11), 6'(FRAC_ONE%12),
      6'(FRAC_ONE%13), 6'(FRAC_ONE%14), 6'(FRAC_ONE%15), 6'(FRAC_ONE%16),
      6'(FRAC_ONE%17), 6'(FRAC_ONE%18), 6'(FRAC_ONE%19), 6'(FRAC_ONE%20),
      6'(FRAC_ONE%21), 6'(FRAC_ONE%22), 6'(FRAC_ONE%23), 6'(FRAC_ONE%24),
      6'(FRAC_ONE%25), 6'(FRAC_ONE%26), 6'(FRAC_ONE%27), 6'(FRAC_ONE%28),
      6'(FRAC_ONE%29), 6'(FRAC_ONE%30), 6'(FRAC_ONE%31), 6'(FRAC_ONE%32),
      6'(FRAC_ONE%33), 6'(FRAC_ONE%34), 6'(FRAC_ONE%35), 6'(FRAC_ONE%36),
      6'(FRAC_ONE%37), 6'(FRAC_ONE%38), 6'(FRAC_ONE%39), 6'(FRAC_ONE%40),
      6'(FRAC_ONE%41), 6'(FRAC_ONE%42), 6'(FRAC_ONE%43), 6'(FRAC_ONE%44),
      6'(FRAC_ONE%45), 6'(FRAC_ONE%46), 6'(FRAC_ONE%47), 6'(FRAC_ONE%48),
      6'(FRAC_ONE%49), 6'(FRAC_ONE%50), 6'(FRAC_ONE%51), 6'(FRAC_ONE%52),
      6'(FRAC_ONE%53), 6'(FRAC_ONE%54), 6'(FRAC_ONE%55), 6'(FRAC_ONE%56),
      6'(FRAC_ONE%57), 6'(FRAC_ONE%58), 6'(FRAC_ONE%59), 6'(FRAC_ONE%60),
      6'(FRAC_ONE%61), 6'(FRAC_ONE%62), 6'(FRAC_ONE%63), 6'(FRAC_ONE%64)
   };

   typedef struct packed {
      logic load;   // capture a new pair, restart step walk
      logic emit;   // produce one result word into the output register
   } rpl_cmd_type;

   typedef struct packed {
      logic last_step;  // current step is the final one for this pair
   } rpl_status_type;

   // a*(1-f) + b*f rewritten as a + (b-a)*f, one signed multiply
   function automatic logic [CH_W-1:0] blend_ch(input logic [CH_W-1:0] a,
                                                input logic [CH_W-1:0] b,
                                                input logic [FRAC_W-1:0] f);
      logic signed [CH_W:0]        diff;
      logic signed [CH_W+FRAC_W:0] prod;
      logic signed [CH_W+FRAC_W:0] sum;
      diff = $signed({1'b0, b}) - $signed({1'b0, a});
      prod = diff * $signed({1'b0, f});
      sum  = $signed({2'b00, a, 12'd0}) + prod;
      return sum[16:12];
   endfunction

endpackage

@@ rtl/rpl_ctrl.sv @@
module rpl_ctrl import rpl_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_tvalid,
   output logic           req_tready,
   input  logic           out_free,
   input  rpl_status_type status,
   output rpl_cmd_type    cmd
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_RUN  = 1'b1;

   logic state_ff, state_in;

   assign req_tready = (state_ff == ST_IDLE);
   assign cmd.load   = req_tvalid && req_tready;
   assign cmd.emit   = (state_ff == ST_RUN) && out_free;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd.load) state_in = ST_RUN;
         end
         ST_RUN: begin
            if (cmd.emit && status.last_step) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

endmodule

@@ rtl/rpl_datapath.sv @@
module rpl_datapath import rpl_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [COUNT_W-1:0]    csr_wdata,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  rpl_cmd_type           cmd,
   output rpl_status_type        status,
   output logic                  out_free,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast
);

   logic [COUNT_W-1:0] cfg_steps_ff;
   logic [COUNT_W-1:0] steps_eff;
   logic [STEP_W-1:0]  tbl_idx;

   // working state of the step walk
   logic [COUNT_W-1:0] steps_ff, steps_in;
   logic [FRAC_W-1:0]  inc_q_ff, inc_q_in;
   logic [STEP_W-1:0]  inc_r_ff, inc_r_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic [FRAC_W-1:0]  frac_ff, frac_in;
   logic [STEP_W-1:0]  rem_ff, rem_in;
   logic [COUNT_W-1:0] rem_sum;

   // held pair
   logic [COLOR_W-1:0] color_a_ff, color_b_ff;
   logic [ENTRY_W-1:0] entry_ff;

   // output register
   logic                  out_valid_ff, out_valid_in;
   logic [RSP_DATA_W-1:0] out_data_ff;
   logic                  out_last_ff;
   logic [COLOR_W-1:0]    blended;

   always_ff @(posedge clock) begin
      if (reset) cfg_steps_ff <= COUNT_W'(RST_STEPS);
      else if (csr_we) cfg_steps_ff <= csr_wdata;
   end

   // zero acts as one, above the maximum saturates
   always_comb begin
      steps_eff = cfg_steps_ff;
      if (cfg_steps_ff == '0) steps_eff = COUNT_W'(1);
      else if (cfg_steps_ff > COUNT_W'(MAX_STEPS)) steps_eff = COUNT_W'(MAX_STEPS);
   end
   assign tbl_idx = STEP_W'(steps_eff - COUNT_W'(1));

   assign status.last_step = ({1'b0, step_ff} + COUNT_W'(1)) == steps_ff;
   assign rem_sum = {1'b0, rem_ff} + {1'b0, inc_r_ff};

   always_comb begin
      steps_in = steps_ff;
      inc_q_in = inc_q_ff;
      inc_r_in = inc_r_ff;
      step_in  = step_ff;
      frac_in  = frac_ff;
      rem_in   = rem_ff;
      if (cmd.load) begin
         steps_in = steps_eff;
         inc_q_in = STEP_Q[tbl_idx];
         inc_r_in = STEP_R[tbl_idx];
         step_in  = '0;
         frac_in  = '0;
         rem_in   = '0;
      end else if (cmd.emit && !status.last_step) begin
         step_in = step_ff + STEP_W'(1);
         // remainder stays below steps, so one compare-subtract carries
         if (rem_sum >= steps_ff) begin
            rem_in  = STEP_W'(rem_sum - steps_ff);
            frac_in = frac_ff + inc_q_ff + FRAC_W'(1);
         end else begin
            rem_in  = STEP_W'(rem_sum);
            frac_in = frac_ff + inc_q_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         steps_ff <= COUNT_W'(1);
         inc_q_ff <= '0;
         inc_r_ff <= '0;
         step_ff  <= '0;
         frac_ff  <= '0;
         rem_ff   <= '0;
      end else begin
         steps_ff <= steps_in;
         inc_q_ff <= inc_q_in;
         inc_r_ff <= inc_r_in;
         step_ff  <= step_in;
         frac_ff  <= frac_in;
         rem_ff   <= rem_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         color_a_ff <= req_tdata[15:0];
         color_b_ff <= req_tdata[31:16];
         entry_ff   <= req_tdata[35:32];
      end
   end

   assign blended = {color_a_ff[15] | color_b_ff[15],
                     blend_ch(color_a_ff[14:10], color_b_ff[14:10], frac_ff),
                     blend_ch(color_a_ff[9:5],   color_b_ff[9:5],   frac_ff),
                     blend_ch(color_a_ff[4:0],   color_b_ff[4:0],   frac_ff)};

   assign out_free = !out_valid_ff || rsp_tready;

   always_comb begin
      out_valid_in = out_valid_ff;
      if (cmd.emit)        out_valid_in = 1'b1;
      else if (rsp_tready) out_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) out_valid_ff <= 1'b0;
      else       out_valid_ff <= out_valid_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         out_data_ff <= {6'd0, entry_ff, step_ff, blended};
         out_last_ff <= status.last_step;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;

   a_load_clears: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> (step_ff == '0) && (frac_ff == '0) && (rem_ff == '0))
      else $error("step walk not restarted on load");

   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      rem_ff < steps_ff)
      else $error("blend remainder out of range");

   a_frac_bound: assert property (@(posedge clock) disable iff (reset)
      frac_ff[FRAC_W-1] == 1'b0)
      else $error("blend factor reached one");

   a_emit_fills: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> rsp_tvalid)
      else $error("emitted word not presented");

endmodule

@@ rtl/rgb555_palette_lerp_unit.sv @@
// channel  dir  word layout (lsb first)                               handshake
// req_     in   tdata: color_a[15:0] color_b[31:16] entry_index[35:32] tvalid/tready
// rsp_     out  tdata: blended_color[15:0] step_index[21:16]          tvalid/tready
//               entry_tag[25:22], tlast = last
// csr_     in   wdata: step_count[6:0]                                 we, no wait
//
// One input word yields S result words, S = step_count (0 reads as 1, >64 as 64).
// Results leave at one per cycle while rsp_tready stays high; the step walk with its
// single blend unit sets that rate.
// The next input is taken once the final result sits in the output register.
// Reset is synchronous; it restores step_count to 16 and empties the output register.
// A stall on rsp_tready freezes the step walk; the output register holds its word.
module rgb555_palette_lerp_unit import rpl_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   // config
   input  logic                  csr_we,
   input  logic [COUNT_W-1:0]    csr_wdata,    // step_count[6:0]
   // input stream
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,    // color_a, color_b, entry_index, pad
   // result stream
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,    // blended_color, step_index, entry_tag, pad
   output logic                  rsp_tlast     // last step of this pair
);

   rpl_cmd_type    cmd;
   rpl_status_type status;
   logic           out_free;

   // sequencer: idle until a pair arrives, then walks its steps
   rpl_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .out_free   (out_free),
      .status     (status),
      .cmd        (cmd)
   );

   // blend factor walk, channel blend and output register
   rpl_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tdata  (req_tdata),
      .cmd        (cmd),
      .status     (status),
      .out_free   (out_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
